// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg
// constants shared by the circle / polyline contact block
// ----------------------------------------------------------------------------
package cpc_pkg;

   // fraction bits of the projection quotient
   localparam int PROJ_BITS = 24;
   // width of the divider step counter
   localparam int PROJ_CNT_BITS = $clog2(PROJ_BITS);

endpackage

// ----- rtl/circle_polyline_contact_core.sv -----
// ----------------------------------------------------------------------------
// circle_polyline_contact_core
// first contact point of a circle with an open polyline
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries one polyline vertex per item together with the circle
//   center, radius and a last mark. every vertex after the first closes a
//   segment; the center is projected onto it (fraction clamped to the ends)
//   and the first point closer than the radius is latched.
//   the item marked last produces one rsp_ item (hit, contact point, zero
//   point when no hit) and clears the polyline state.
// timing:
//   one shared multiplier and a restoring divider under a small sequencer.
//   a segment test runs setup (deltas, squared length, dot product), for an
//   interior projection the 24 divider steps and the offset, then the
//   distance test; a vertex with no segment goes straight to finish. the
//   24-step divider sets the rate. req_stall is high while an item is in work.
// reset: synchronous, clears the sequencer, the polyline state and rsp_valid.
// stall: a result waits in the output register while rsp_stall is high; the
//   next item is still taken, and only a second last item waits for it.
// ----------------------------------------------------------------------------
module circle_polyline_contact_core
   import cpc_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic        [COORD_BITS-2:0] req_radius,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [COORD_BITS-1:0] rsp_contact_x,
   output logic signed [COORD_BITS-1:0] rsp_contact_y
);

   localparam int W  = COORD_BITS;
   localparam int MW = W + 1;
   localparam int OW = (MW > PROJ_BITS) ? MW : PROJ_BITS;
   localparam int PW = 2 * OW;
   localparam int DW = PW + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DELTA, S_LXX, S_LYY, S_M1, S_M2, S_CLAMP, S_DIV,
      S_OFFX, S_OFFY, S_R2, S_SQX, S_SQY, S_FINISH
   } state_type;

   state_type state_ff;

   logic signed [W-1:0]  bx_ff, by_ff, cx_ff, cy_ff;
   logic        [W-2:0]  r_ff;
   logic                 last_ff;
   logic signed [W-1:0]  prev_x_ff, prev_y_ff, found_x_ff, found_y_ff;
   logic                 have_prev_ff, found_ff;
   logic signed [MW-1:0] abx_ff, aby_ff, apx_ff, apy_ff;
   logic signed [W-1:0]  px_ff, py_ff;
   logic        [PW-1:0] len2_ff, r2_ff, dist_ff;
   logic signed [DW-1:0] dot_ff;
   logic        [DW-1:0] rem_ff;
   logic [PROJ_BITS-1:0] q_ff;
   logic [PROJ_CNT_BITS-1:0] cnt_ff;
   logic                 rsp_valid_ff, rsp_hit_ff;
   logic signed [W-1:0]  rsp_x_ff, rsp_y_ff;

   // magnitude of a signed delta
   function automatic logic [OW-1:0] mag(input logic signed [MW-1:0] v);
      logic signed [MW-1:0] n;
      n = -v;
      return v[MW-1] ? OW'(unsigned'(n)) : OW'(unsigned'(v));
   endfunction

   // shared multiplier operand select
   logic [OW-1:0] mul_a, mul_b;
   logic [PW-1:0] mul_p;
   logic signed [MW-1:0] dx, dy;

   assign dx = MW'(px_ff) - MW'(cx_ff);
   assign dy = MW'(py_ff) - MW'(cy_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_LXX:   begin mul_a = mag(abx_ff); mul_b = mag(abx_ff); end
         S_LYY:   begin mul_a = mag(aby_ff); mul_b = mag(aby_ff); end
         S_M1:    begin mul_a = mag(abx_ff); mul_b = mag(apx_ff); end
         S_M2:    begin mul_a = mag(aby_ff); mul_b = mag(apy_ff); end
         S_OFFX:  begin mul_a = mag(abx_ff); mul_b = OW'(q_ff); end
         S_OFFY:  begin mul_a = mag(aby_ff); mul_b = OW'(q_ff); end
         S_R2:    begin mul_a = OW'(r_ff);   mul_b = OW'(r_ff); end
         S_SQX:   begin mul_a = mag(dx);     mul_b = mag(dx); end
         S_SQY:   begin mul_a = mag(dy);     mul_b = mag(dy); end
         default: begin mul_a = '0;          mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // signed product for the dot accumulation
   logic prod_neg;
   logic signed [DW-1:0] prod_s;
   always_comb begin
      prod_neg = (state_ff == S_M1) ? (abx_ff[MW-1] ^ apx_ff[MW-1])
                                    : (aby_ff[MW-1] ^ apy_ff[MW-1]);
      prod_s = prod_neg ? -signed'({1'b0, mul_p}) : signed'({1'b0, mul_p});
   end

   // rounded offset along the segment
   logic [PW-1:0] off_round;
   logic signed [MW:0] off_s, pos_new;
   logic signed [MW-1:0] off_delta;
   always_comb begin
      off_round = (mul_p + (PW'(1) << (PROJ_BITS - 1))) >> PROJ_BITS;
      off_delta = (state_ff == S_OFFX) ? abx_ff : aby_ff;
      off_s = off_delta[MW-1] ? -signed'(off_round[MW:0]) : signed'(off_round[MW:0]);
      pos_new = ((state_ff == S_OFFX) ? (MW+1)'(prev_x_ff) : (MW+1)'(prev_y_ff)) + off_s;
   end

   // divider step
   logic [DW-1:0] div_diff;
   logic          div_ge;
   assign div_diff = DW'(len2_ff) - rem_ff;
   assign div_ge   = rem_ff >= div_diff;

   // squared distance test
   logic [PW:0] dist_sum;
   assign dist_sum = (PW+1)'(dist_ff) + (PW+1)'(mul_p);

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         found_ff     <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         found_x_ff   <= '0;
         found_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result taken, unless a new one replaces it this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_FINISH || !last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  bx_ff   <= req_vertex_x;
                  by_ff   <= req_vertex_y;
                  cx_ff   <= req_center_x;
                  cy_ff   <= req_center_y;
                  r_ff    <= req_radius;
                  last_ff <= req_last;
                  state_ff <= (have_prev_ff && !found_ff) ? S_DELTA : S_FINISH;
               end
            end
            S_DELTA: begin
               abx_ff   <= MW'(bx_ff) - MW'(prev_x_ff);
               aby_ff   <= MW'(by_ff) - MW'(prev_y_ff);
               apx_ff   <= MW'(cx_ff) - MW'(prev_x_ff);
               apy_ff   <= MW'(cy_ff) - MW'(prev_y_ff);
               state_ff <= S_LXX;
            end
            S_LXX: begin
               len2_ff  <= mul_p;
               state_ff <= S_LYY;
            end
            S_LYY: begin
               len2_ff  <= len2_ff + mul_p;
               state_ff <= S_M1;
            end
            S_M1: begin
               dot_ff   <= prod_s;
               state_ff <= S_M2;
            end
            S_M2: begin
               dot_ff   <= dot_ff + prod_s;
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               priority if (len2_ff == '0 || dot_ff < 0) begin
                  px_ff    <= prev_x_ff;
                  py_ff    <= prev_y_ff;
                  state_ff <= S_R2;
               end else if (dot_ff >= signed'({1'b0, len2_ff})) begin
                  px_ff    <= bx_ff;
                  py_ff    <= by_ff;
                  state_ff <= S_R2;
               end else begin
                  rem_ff   <= unsigned'(dot_ff);
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= div_ge ? (rem_ff - div_diff) : (rem_ff << 1);
               q_ff   <= {q_ff[PROJ_BITS-2:0], div_ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == PROJ_CNT_BITS'(PROJ_BITS - 1)) begin
                  state_ff <= S_OFFX;
               end
            end
            S_OFFX: begin
               px_ff    <= pos_new[W-1:0];
               state_ff <= S_OFFY;
            end
            S_OFFY: begin
               py_ff    <= pos_new[W-1:0];
               state_ff <= S_R2;
            end
            S_R2: begin
               r2_ff    <= mul_p;
               state_ff <= S_SQX;
            end
            S_SQX: begin
               dist_ff  <= mul_p;
               state_ff <= S_SQY;
            end
            S_SQY: begin
               if (dist_sum < (PW+1)'(r2_ff)) begin
                  found_ff   <= 1'b1;
                  found_x_ff <= px_ff;
                  found_y_ff <= py_ff;
               end
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (!last_ff) begin
                  prev_x_ff    <= bx_ff;
                  prev_y_ff    <= by_ff;
                  have_prev_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= found_ff;
                  rsp_x_ff     <= found_ff ? found_x_ff : '0;
                  rsp_y_ff     <= found_ff ? found_y_ff : '0;
                  prev_x_ff    <= '0;
                  prev_y_ff    <= '0;
                  found_x_ff   <= '0;
                  found_y_ff   <= '0;
                  have_prev_ff <= 1'b0;
                  found_ff     <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_contact_x = rsp_x_ff;
   assign rsp_contact_y = rsp_y_ff;

endmodule

// ----- rtl/cpc_checker.sv -----
// ----------------------------------------------------------------------------
// cpc_checker
// port-level checks on the circle / polyline contact block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpc_checker #(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_hit,
   input logic signed [COORD_BITS-1:0] rsp_contact_x,
   input logic signed [COORD_BITS-1:0] rsp_contact_y
);

   // a stalled result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a miss reports the zero point
   `ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_contact_x == '0 && rsp_contact_y == '0)

   // an accepted item makes the block busy in the cycle after
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a new result only comes out of a busy cycle
   `ASSERT_IMPLIES(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind circle_polyline_contact_core cpc_checker #(.COORD_BITS(COORD_BITS)) u_cpc_checker (.*);
